// ===== rtl/apc_pkg.sv =====
package apc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned THR_W  = 24;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [THR_W-1:0] EDGE_DEBOUNCE_RST = THR_W'(2000);
  localparam logic [THR_W-1:0] MIN_HIGH_RST      = THR_W'(5000);
  localparam logic [THR_W-1:0] MIN_CYCLE_RST     = THR_W'(50000);
  localparam logic [THR_W-1:0] PARK_HIGH_RST     = THR_W'(2000000);
  localparam logic [THR_W-1:0] MIN_LOW_RST       = THR_W'(5000);
  localparam logic [THR_W-1:0] REARM_LOW_RST     = THR_W'(200000);
  localparam logic             ACTIVE_HIGH_RST   = 1'b1;

  typedef enum logic [2:0] {
    REG_EDGE_DEBOUNCE = 3'd0,
    REG_MIN_HIGH      = 3'd1,
    REG_MIN_CYCLE     = 3'd2,
    REG_PARK_HIGH     = 3'd3,
    REG_MIN_LOW       = 3'd4,
    REG_REARM_LOW     = 3'd5,
    REG_ACTIVE_HIGH   = 3'd6
  } apc_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] edge_debounce_us;
    logic [THR_W-1:0] hi_min_us;
    logic [THR_W-1:0] cyc_gap_us;
    logic [THR_W-1:0] park_high_us;
    logic [THR_W-1:0] lo_arm_us;
    logic [THR_W-1:0] lo_unpark_us;
    logic             pol_high;
  } apc_cfg_t;

  typedef struct packed {
    logic              mode;
    logic              level;
    logic [TIME_W-1:0] time_us;
  } apc_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] revolutions;
    logic              counted;
    logic              is_armed;
    logic              is_parked;
  } apc_result_t;

endpackage

// ===== rtl/armed_pulse_counter_with_park.sv =====
// Data path: a transaction accepted into the input register (s1_item_r) has its result
// loaded into the output register (out_r) when that stage advances.
// Throughput: one transaction per cycle unless out_stall holds a result; a single input
// stage and output register decouple the channels; core state and out_r load on one step.
// Reset (rst_n low, synchronous): pipeline empty, state and config registers reset.
module armed_pulse_counter_with_park import apc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic              in_level,
  input  logic [TIME_W-1:0] in_time_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TIME_W-1:0] out_revolutions,
  output logic              out_counted,
  output logic              out_is_armed,
  output logic              out_is_parked,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  apc_cfg_t    cfg;
  apc_item_t   s1_item_r;
  logic        s1_valid_r, s1_valid_nxt;
  apc_result_t res, out_r;
  logic        out_valid_r, out_valid_nxt;
  logic        advance, in_acc, step;

  assign advance  = ~(out_valid_r & out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign in_acc   = in_valid & ~in_stall;
  assign step     = s1_valid_r & advance;

  assign s1_valid_nxt  = in_acc | (s1_valid_r & ~step);
  assign out_valid_nxt = step | (out_valid_r & out_stall);

  apc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.mode    <= in_mode;
      s1_item_r.level   <= in_level;
      s1_item_r.time_us <= in_time_us;
    end
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_revolutions = out_r.revolutions;
  assign out_counted     = out_r.counted;
  assign out_is_armed    = out_r.is_armed;
  assign out_is_parked   = out_r.is_parked;

endmodule

// ===== rtl/apc_cfg.sv =====
module apc_cfg import apc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output apc_cfg_t          cfg
);

  apc_cfg_t cfg_r;
  apc_cfg_t cfg_nxt;
  apc_reg_t sel;
  logic     wr;

  assign sel    = apc_reg_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (sel)
        REG_EDGE_DEBOUNCE: cfg_nxt.edge_debounce_us = pwdata[THR_W-1:0];
        REG_MIN_HIGH:      cfg_nxt.hi_min_us        = pwdata[THR_W-1:0];
        REG_MIN_CYCLE:     cfg_nxt.cyc_gap_us       = pwdata[THR_W-1:0];
        REG_PARK_HIGH:     cfg_nxt.park_high_us     = pwdata[THR_W-1:0];
        REG_MIN_LOW:       cfg_nxt.lo_arm_us        = pwdata[THR_W-1:0];
        REG_REARM_LOW:     cfg_nxt.lo_unpark_us     = pwdata[THR_W-1:0];
        REG_ACTIVE_HIGH:   cfg_nxt.pol_high         = pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_EDGE_DEBOUNCE: prdata = DATA_W'(cfg_r.edge_debounce_us);
      REG_MIN_HIGH:      prdata = DATA_W'(cfg_r.hi_min_us);
      REG_MIN_CYCLE:     prdata = DATA_W'(cfg_r.cyc_gap_us);
      REG_PARK_HIGH:     prdata = DATA_W'(cfg_r.park_high_us);
      REG_MIN_LOW:       prdata = DATA_W'(cfg_r.lo_arm_us);
      REG_REARM_LOW:     prdata = DATA_W'(cfg_r.lo_unpark_us);
      REG_ACTIVE_HIGH:   prdata = DATA_W'(cfg_r.pol_high);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_debounce_us <= EDGE_DEBOUNCE_RST;
      cfg_r.hi_min_us        <= MIN_HIGH_RST;
      cfg_r.cyc_gap_us       <= MIN_CYCLE_RST;
      cfg_r.park_high_us     <= PARK_HIGH_RST;
      cfg_r.lo_arm_us        <= MIN_LOW_RST;
      cfg_r.lo_unpark_us     <= REARM_LOW_RST;
      cfg_r.pol_high         <= ACTIVE_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/apc_core.sv =====
module apc_core import apc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  apc_cfg_t    cfg,
  input  logic        step,
  input  apc_item_t   item,
  output apc_result_t res
);

  logic              prev_level_r, prev_level_nxt;
  logic [TIME_W-1:0] edge_time_r, edge_time_nxt;
  logic [TIME_W-1:0] high_start_r, high_start_nxt;
  logic              high_valid_r, high_valid_nxt;
  logic [TIME_W-1:0] low_start_r, low_start_nxt;
  logic              low_valid_r, low_valid_nxt;
  logic              armed_r, armed_nxt;
  logic              parked_r, parked_nxt;
  logic [TIME_W-1:0] count_time_r, count_time_nxt;
  logic [TIME_W-1:0] count_r, count_nxt;

  logic              act;
  logic [TIME_W-1:0] d_edge, d_high, d_low, d_cyc, hd_a, ld_a;
  logic              edge_ok, rise, fall, park_fall, do_count;
  logic              hv_a, lv_a, armed_a, park_go, arm_go, unpark;

  always_comb begin
    act       = cfg.pol_high ? item.level : ~item.level;
    d_edge    = item.time_us - edge_time_r;
    d_high    = item.time_us - high_start_r;
    d_low     = item.time_us - low_start_r;
    d_cyc     = item.time_us - count_time_r;
    edge_ok   = (item.level != prev_level_r) &&
                (d_edge >= TIME_W'(cfg.edge_debounce_us));
    rise      = edge_ok & act;
    fall      = edge_ok & ~act;
    park_fall = fall & parked_r;
    do_count  = fall & ~parked_r & high_valid_r & armed_r &
                (d_high >= TIME_W'(cfg.hi_min_us)) &
                (d_cyc >= TIME_W'(cfg.cyc_gap_us));
    hv_a      = rise ? 1'b1 : ((fall & ~parked_r) ? 1'b0 : high_valid_r);
    lv_a      = fall | low_valid_r;
    hd_a      = rise ? '0 : d_high;
    ld_a      = fall ? '0 : d_low;
    armed_a   = do_count ? 1'b0 : armed_r;
    park_go   = ~parked_r & act & hv_a & (hd_a >= TIME_W'(cfg.park_high_us));
    arm_go    = ~parked_r & ~act & lv_a & (ld_a >= TIME_W'(cfg.lo_arm_us));
    unpark    = parked_r & ~act & lv_a & ~park_fall &
                (ld_a >= TIME_W'(cfg.lo_unpark_us));
  end

  always_comb begin
    prev_level_nxt = edge_ok ? item.level : prev_level_r;
    edge_time_nxt  = edge_ok ? item.time_us : edge_time_r;
    high_start_nxt = rise ? item.time_us : high_start_r;
    high_valid_nxt = unpark ? 1'b0 : hv_a;
    low_start_nxt  = (fall | unpark) ? item.time_us : low_start_r;
    low_valid_nxt  = lv_a;
    count_nxt      = do_count ? count_r + TIME_W'(1) : count_r;
    count_time_nxt = do_count ? item.time_us : count_time_r;
    parked_nxt     = park_go ? 1'b1 : (unpark ? 1'b0 : parked_r);
    armed_nxt      = (park_go | unpark) ? 1'b0 : (arm_go ? 1'b1 : armed_a);
    res.counted    = do_count;
    if (item.mode) begin
      prev_level_nxt = item.level;
      edge_time_nxt  = item.time_us;
      high_start_nxt = act ? item.time_us : '0;
      high_valid_nxt = act;
      low_start_nxt  = act ? '0 : item.time_us;
      low_valid_nxt  = ~act;
      armed_nxt      = ~act;
      parked_nxt     = 1'b0;
      count_nxt      = '0;
      count_time_nxt = '0;
      res.counted    = 1'b0;
    end
    res.revolutions = count_nxt;
    res.is_armed    = armed_nxt;
    res.is_parked   = parked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      edge_time_r  <= '0;
      high_start_r <= '0;
      high_valid_r <= 1'b0;
      low_start_r  <= '0;
      low_valid_r  <= 1'b1;
      armed_r      <= 1'b1;
      parked_r     <= 1'b0;
      count_time_r <= '0;
      count_r      <= '0;
    end else if (step) begin
      prev_level_r <= prev_level_nxt;
      edge_time_r  <= edge_time_nxt;
      high_start_r <= high_start_nxt;
      high_valid_r <= high_valid_nxt;
      low_start_r  <= low_start_nxt;
      low_valid_r  <= low_valid_nxt;
      armed_r      <= armed_nxt;
      parked_r     <= parked_nxt;
      count_time_r <= count_time_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

// ===== rtl/apc_checker.sv =====
module apc_checker import apc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [TIME_W-1:0] out_revolutions,
  input logic              out_counted,
  input logic              out_is_armed,
  input logic              out_is_parked
);

  // stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_revolutions) && $stable(out_counted) &&
                               $stable(out_is_armed) && $stable(out_is_parked))
    else $error("stalled result changed");

  // a count is only taken while unparked
  a_count_unparked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_counted |-> !out_is_parked)
    else $error("count reported while parked");

  // park lock always disarms
  a_park_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_parked |-> !out_is_armed)
    else $error("armed while parked");

endmodule

bind armed_pulse_counter_with_park apc_checker u_apc_checker (.*);
